>>> hdl/htkv_pkg.sv
// ----------------------------------------------------------------------------
// Hash table key/value store package
// Field widths, request codes and the slot layout shared by the store.
// ----------------------------------------------------------------------------
`default_nettype none

package htkv_pkg;

	localparam int KEY_W  = 31;
	localparam int VAL_W  = 32;
	localparam int REQ_W  = 2;
	localparam int MULT_W = KEY_W + 1;
	localparam int PROD_W = KEY_W + MULT_W;

	typedef enum logic [REQ_W-1:0] {
		REQ_GET = 2'd0,
		REQ_PUT = 2'd1,
		REQ_DEL = 2'd2
	} req_t;

	typedef enum logic {
		ST_CLEAR,
		ST_RUN
	} state_t;

	typedef struct packed {
		logic             vld;
		logic [KEY_W-1:0] key;
		logic [VAL_W-1:0] val;
	} slot_t;

endpackage

`default_nettype wire

>>> hdl/hash_table_key_value_store.sv
// ----------------------------------------------------------------------------
// Hash table key/value store
// Bucketed key/value table with a fixed number of ways per bucket, handling
// get, put and delete requests against one row memory.
// ----------------------------------------------------------------------------
// Usage:
// A request beat (req_type, lookup_key, write_value) is taken on in_valid and
// in_ready. Each request yields exactly one result beat (found, read_value,
// bucket_full) on out_valid and out_ready, in request order.
// The bucket is the key modulo NUM_BUCKETS, formed by a reciprocal multiply
// over two stages. The third stage holds the registered bucket row, compares
// all ways at once and writes the updated row back; a row written in one
// cycle is forwarded to a request that read the same row in that cycle.
// An accepted request passes through the stages and then the result register to reach out_valid.
// Throughput is one request per cycle while results are taken, set by the single
// read and single write port of the row memory being used once each per request.
// After reset the block sweeps the row memory, one bucket per cycle, to mark
// every way empty; in_ready stays low during the sweep.
// When the receiver stalls with a result waiting, the pipeline keeps moving
// until a request reaches the last stage; it then holds and in_ready falls
// until the result beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module hash_table_key_value_store #(
	parameter int NUM_BUCKETS = 128,
	parameter int WAYS        = 4
) (
	input  wire logic                       clk,
	input  wire logic                       arst_n,
	input  wire logic                       in_valid,
	output logic                            in_ready,
	input  wire logic [htkv_pkg::REQ_W-1:0] req_type,
	input  wire logic [htkv_pkg::KEY_W-1:0] lookup_key,
	input  wire logic [htkv_pkg::VAL_W-1:0] write_value,
	output logic                            out_valid,
	input  wire logic                       out_ready,
	output logic                            found,
	output logic [htkv_pkg::VAL_W-1:0]      read_value,
	output logic                            bucket_full
);

	import htkv_pkg::*;

	localparam int BKT_W = (NUM_BUCKETS > 1) ? $clog2(NUM_BUCKETS) : 1;
	localparam int WAY_W = (WAYS > 1) ? $clog2(WAYS) : 1;
	localparam int SHIFT = KEY_W + BKT_W;
	localparam logic [63:0] RECIP =
		((64'd1 << SHIFT) + 64'(NUM_BUCKETS) - 64'd1) / 64'(NUM_BUCKETS);
	localparam logic [MULT_W-1:0] MULT = RECIP[MULT_W-1:0];
	localparam logic [BKT_W-1:0] N_LO = BKT_W'(NUM_BUCKETS);
	localparam logic [BKT_W-1:0] LAST_BKT = BKT_W'(NUM_BUCKETS - 1);

	state_t state_q, state_d;
	logic clearing;
	logic [BKT_W-1:0] clr_addr_q;

	logic adv;

	logic             vld_s1, vld_s2, vld_s3;
	req_t             req_s1, req_s2, req_s3;
	logic [KEY_W-1:0] key_s1, key_s2, key_s3;
	logic [VAL_W-1:0] val_s1, val_s2, val_s3;
	logic [PROD_W-1:0] prod_c, prod_s2;
	logic [BKT_W-1:0] q_lo, qn_lo, bucket_c, bucket_s3;
	logic             fwd_s3;

	slot_t [WAYS-1:0] mem [NUM_BUCKETS];
	slot_t [WAYS-1:0] rd_row_s3, wr_row_q, row_c, new_row;
	logic             mem_we;
	logic [BKT_W-1:0] mem_waddr;
	slot_t [WAYS-1:0] mem_wdata;

	logic [WAYS-1:0]  hit_c, free_c;
	logic [WAY_W-1:0] hit_idx, free_idx;
	logic             found_c, full_c;
	logic [VAL_W-1:0] rdval_c;

	logic             out_valid_q, found_q, full_q;
	logic [VAL_W-1:0] rdval_q;

	// Clearing sequencer.
	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_CLEAR: begin
				if (clr_addr_q == LAST_BKT) begin
					state_d = ST_RUN;
				end
			end
			ST_RUN: begin
				state_d = ST_RUN;
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end

	always_comb begin
		case (state_q)
			ST_CLEAR: clearing = 1'b1;
			ST_RUN:   clearing = 1'b0;
			default:  clearing = 1'b1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q    <= ST_CLEAR;
			clr_addr_q <= '0;
		end else begin
			state_q <= state_d;
			if (clearing) begin
				clr_addr_q <= clr_addr_q + 1'b1;
			end
		end
	end

	assign adv      = !vld_s3 || !out_valid_q || out_ready;
	assign in_ready = adv && !clearing;

	// Bucket index: quotient by reciprocal, remainder from its low bits.
	assign prod_c   = PROD_W'(key_s1) * PROD_W'(MULT);
	assign q_lo     = prod_s2[SHIFT +: BKT_W];
	assign qn_lo    = q_lo * N_LO;
	assign bucket_c = key_s2[BKT_W-1:0] - qn_lo;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_s1 <= 1'b0;
			vld_s2 <= 1'b0;
			vld_s3 <= 1'b0;
			fwd_s3 <= 1'b0;
		end else if (adv) begin
			vld_s1 <= in_valid && in_ready;
			vld_s2 <= vld_s1;
			vld_s3 <= vld_s2;
			fwd_s3 <= vld_s3 && vld_s2 && (bucket_c == bucket_s3);
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			req_s1    <= req_t'(req_type);
			key_s1    <= lookup_key;
			val_s1    <= write_value;
			req_s2    <= req_s1;
			key_s2    <= key_s1;
			val_s2    <= val_s1;
			prod_s2   <= prod_c;
			req_s3    <= req_s2;
			key_s3    <= key_s2;
			val_s3    <= val_s2;
			bucket_s3 <= bucket_c;
			if (vld_s3) begin
				wr_row_q <= new_row;
			end
		end
	end

	// Row memory.
	assign mem_we    = clearing || (vld_s3 && adv);
	assign mem_waddr = clearing ? clr_addr_q : bucket_s3;
	assign mem_wdata = clearing ? '0 : new_row;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (adv) begin
			rd_row_s3 <= mem[bucket_c];
		end
	end

	// Way compare and lowest-numbered selection.
	always_comb begin
		row_c    = fwd_s3 ? wr_row_q : rd_row_s3;
		hit_c    = '0;
		free_c   = '0;
		hit_idx  = '0;
		free_idx = '0;
		for (int w = 0; w < WAYS; w++) begin
			hit_c[w]  = row_c[w].vld && (row_c[w].key == key_s3);
			free_c[w] = !row_c[w].vld;
		end
		for (int w = WAYS - 1; w >= 0; w--) begin
			if (hit_c[w]) begin
				hit_idx = WAY_W'(w);
			end
			if (free_c[w]) begin
				free_idx = WAY_W'(w);
			end
		end
	end

	always_comb begin
		new_row = row_c;
		found_c = |hit_c;
		rdval_c = '1;
		full_c  = 1'b0;
		case (req_s3)
			REQ_GET: begin
				if (|hit_c) begin
					rdval_c = row_c[hit_idx].val;
				end
			end
			REQ_PUT: begin
				if (|hit_c) begin
					new_row[hit_idx].val = val_s3;
				end else if (|free_c) begin
					new_row[free_idx].vld = 1'b1;
					new_row[free_idx].key = key_s3;
					new_row[free_idx].val = val_s3;
				end else begin
					full_c = 1'b1;
				end
			end
			REQ_DEL: begin
				if (|hit_c) begin
					new_row[hit_idx].vld = 1'b0;
				end
			end
			default: begin
				found_c = 1'b0;
			end
		endcase
	end

	// Result register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (vld_s3 && adv) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (vld_s3 && adv) begin
			found_q <= found_c;
			rdval_q <= rdval_c;
			full_q  <= full_c;
		end
	end

	assign out_valid   = out_valid_q;
	assign found       = found_q;
	assign read_value  = rdval_q;
	assign bucket_full = full_q;

	a_bucket_in_range: assert property (@(posedge clk) disable iff (!arst_n)
		vld_s3 |-> (bucket_s3 <= LAST_BKT))
		else $error("bucket index beyond the bucket count");

	a_no_request_while_clearing: assert property (@(posedge clk) disable iff (!arst_n)
		clearing |-> (!vld_s1 && !vld_s2 && !vld_s3))
		else $error("request in flight during the clearing sweep");

	a_full_excludes_found: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> !(bucket_full && found))
		else $error("result beat reports both a hit and a full bucket");

	a_value_needs_hit: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && (read_value != '1)) |-> found)
		else $error("stored value returned without a hit");

	a_fwd_only_with_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_s3 |-> vld_s3)
		else $error("row forwarding selected with no request in the last stage");

endmodule

`default_nettype wire

>>> verif/tb_hash_table_key_value_store.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Hash table key/value store testbench
// Sends get, put and delete requests, some of them with the unused request
// code, and predicts every result from a private copy of the bucket table.
// Directed corner cases come first. Random traffic over a few crowded buckets
// follows, with idle gaps on the request side and stalls on the result side.
// The run ends with a stretch at full rate on both sides.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_hash_table_key_value_store;

	import htkv_pkg::*;

	localparam int NUM_BUCKETS = 128;
	localparam int WAYS        = 4;
	localparam int SLOTS       = NUM_BUCKETS * WAYS;
	localparam int POOL_SIZE   = 40;
	localparam int LIMIT       = 200000;

	localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
	localparam logic [VAL_W-1:0] NO_VALUE   = {VAL_W{1'b1}};
	localparam logic [KEY_W-1:0] KEY_MAX    = {KEY_W{1'b1}};

	typedef struct packed {
		logic             found;
		logic [VAL_W-1:0] read_value;
		logic             bucket_full;
	} lookup_result_t;

	logic             clk = 1'b0;
	logic             arst_n = 1'b0;
	logic             in_valid = 1'b0;
	logic             in_ready;
	logic [REQ_W-1:0] req_type = REQ_GET;
	logic [KEY_W-1:0] lookup_key = '0;
	logic [VAL_W-1:0] write_value = '0;
	logic             out_valid;
	logic             out_ready = 1'b0;
	logic             found;
	logic [VAL_W-1:0] read_value;
	logic             bucket_full;

	// Private copy of the table.
	logic             tbl_valid [SLOTS];
	logic [KEY_W-1:0] tbl_key   [SLOTS];
	logic [VAL_W-1:0] tbl_value [SLOTS];

	lookup_result_t   pending_results [$];
	lookup_result_t   want;
	logic [KEY_W-1:0] key_pool [POOL_SIZE];

	int  cycle_count = 0;
	int  fail_count = 0;
	int  request_count = 0;
	int  hit_count = 0;
	int  full_count = 0;
	int  stall_left = 0;
	bit  feed_gaps = 1'b0;
	bit  sink_gaps = 1'b0;

	hash_table_key_value_store #(
		.NUM_BUCKETS(NUM_BUCKETS),
		.WAYS(WAYS)
	) uut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_ready(in_ready),
		.req_type(req_type),
		.lookup_key(lookup_key),
		.write_value(write_value),
		.out_valid(out_valid),
		.out_ready(out_ready),
		.found(found),
		.read_value(read_value),
		.bucket_full(bucket_full)
	);

	always begin
		#6 clk = 1'b1;
		#6 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > LIMIT) begin
			$display("hash_table_key_value_store test failed");
			$finish;
		end
	end

	function automatic lookup_result_t apply_request(input logic [REQ_W-1:0] req,
			input logic [KEY_W-1:0] key, input logic [VAL_W-1:0] val);
		lookup_result_t res;
		int base;
		int hit_way;
		int free_way;
		base = (key % NUM_BUCKETS) * WAYS;
		hit_way = -1;
		free_way = -1;
		res.found = 1'b0;
		res.read_value = NO_VALUE;
		res.bucket_full = 1'b0;
		for (int w = 0; w < WAYS; w++) begin
			if (tbl_valid[base + w]) begin
				if (hit_way < 0 && tbl_key[base + w] == key)
					hit_way = w;
			end else if (free_way < 0) begin
				free_way = w;
			end
		end
		res.found = (hit_way >= 0);
		case (req)
			REQ_GET: begin
				if (hit_way >= 0)
					res.read_value = tbl_value[base + hit_way];
			end
			REQ_PUT: begin
				if (hit_way >= 0) begin
					tbl_value[base + hit_way] = val;
				end else if (free_way >= 0) begin
					tbl_valid[base + free_way] = 1'b1;
					tbl_key[base + free_way] = key;
					tbl_value[base + free_way] = val;
				end else begin
					res.bucket_full = 1'b1;
				end
			end
			REQ_DEL: begin
				if (hit_way >= 0)
					tbl_valid[base + hit_way] = 1'b0;
			end
			default: begin
				res.found = 1'b0;
			end
		endcase
		return res;
	endfunction

	task automatic send_request(input logic [REQ_W-1:0] req, input logic [KEY_W-1:0] key,
			input logic [VAL_W-1:0] val);
		lookup_result_t res;
		@(negedge clk);
		if (feed_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 5)) @(negedge clk);
		end
		in_valid <= 1'b1;
		req_type <= req;
		lookup_key <= key;
		write_value <= val;
		do @(posedge clk); while (!in_ready);
		res = apply_request(req, key, val);
		pending_results.push_back(res);
		request_count++;
		if (res.found)
			hit_count++;
		if (res.bucket_full)
			full_count++;
	endtask

	// Result side: stalls come in bursts while sink_gaps is set.
	always @(negedge clk) begin
		if (stall_left != 0) begin
			stall_left <= stall_left - 1;
			out_ready <= 1'b0;
		end else if (sink_gaps && $urandom_range(0, 7) == 0) begin
			stall_left <= $urandom_range(0, 4);
			out_ready <= 1'b0;
		end else begin
			out_ready <= 1'b1;
		end
	end

	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready) begin
			if (pending_results.size() == 0) begin
				$display("%0t: result beat with no request outstanding", $time);
				fail_count++;
			end else begin
				want = pending_results.pop_front();
				if (found !== want.found) begin
					$display("%0t: found expected %0b actual %0b", $time, want.found, found);
					fail_count++;
				end
				if (read_value !== want.read_value) begin
					$display("%0t: read_value expected %h actual %h", $time,
						want.read_value, read_value);
					fail_count++;
				end
				if (bucket_full !== want.bucket_full) begin
					$display("%0t: bucket_full expected %0b actual %0b", $time,
						want.bucket_full, bucket_full);
					fail_count++;
				end
			end
		end
	end

	task automatic test_directed;
		send_request(REQ_GET, '0, '0);
		send_request(REQ_PUT, '0, 32'h7FFF_FFFF);
		send_request(REQ_GET, '0, '0);
		send_request(REQ_PUT, KEY_MAX, 32'h8000_0000);
		send_request(REQ_GET, KEY_MAX, '0);
		send_request(REQ_PUT, KEY_MAX, 32'hFFFF_FFFF);
		send_request(REQ_GET, KEY_MAX, 32'h1234_5678);
		send_request(REQ_UNUSED, '0, 32'h5555_AAAA);
		send_request(REQ_DEL, '0, '0);
		send_request(REQ_DEL, '0, '0);
		send_request(REQ_GET, '0, '0);
		// Five keys in one bucket: the fifth finds no free way.
		for (int i = 0; i < 5; i++)
			send_request(REQ_PUT, 31'd5 + 31'(i * NUM_BUCKETS), 32'hA000_0000 + i);
		send_request(REQ_GET, 31'd517, '0);
		// Freeing the first way lets the next new key take it.
		send_request(REQ_DEL, 31'd5, '0);
		send_request(REQ_PUT, 31'd517, 32'hC0DE_0517);
		send_request(REQ_GET, 31'd517, '0);
		send_request(REQ_GET, 31'd133, '0);
		send_request(REQ_PUT, 31'd645, 32'h0000_0645);
		send_request(REQ_DEL, 31'd1, '0);
	endtask

	task automatic fill_key_pool;
		logic [31:0] rnd;
		int          bkt;
		for (int i = 0; i < POOL_SIZE; i++) begin
			rnd = $urandom();
			case (i % 6)
				0: bkt = 0;
				1: bkt = 3;
				2: bkt = 45;
				3: bkt = 64;
				4: bkt = 90;
				default: bkt = NUM_BUCKETS - 1;
			endcase
			key_pool[i] = KEY_W'(rnd[KEY_W-1:0] - (rnd[KEY_W-1:0] % NUM_BUCKETS) + bkt);
		end
	endtask

	task automatic random_request;
		logic [31:0]      rnd;
		logic [KEY_W-1:0] key;
		logic [REQ_W-1:0] req;
		int               pick;
		rnd = $urandom();
		if ($urandom_range(0, 9) == 0)
			key = rnd[KEY_W-1:0];
		else
			key = key_pool[$urandom_range(0, POOL_SIZE - 1)];
		pick = $urandom_range(0, 99);
		if (pick < 40)
			req = REQ_GET;
		else if (pick < 75)
			req = REQ_PUT;
		else if (pick < 95)
			req = REQ_DEL;
		else
			req = REQ_UNUSED;
		send_request(req, key, $urandom());
	endtask

	task automatic test_random_traffic;
		feed_gaps = 1'b1;
		sink_gaps = 1'b1;
		repeat (700)
			random_request();
	endtask

	task automatic test_full_rate;
		feed_gaps = 1'b0;
		sink_gaps = 1'b0;
		repeat (150)
			random_request();
	endtask

	initial begin
		for (int i = 0; i < SLOTS; i++) begin
			tbl_valid[i] = 1'b0;
			tbl_key[i] = '0;
			tbl_value[i] = '0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		fill_key_pool();
		test_directed();
		test_random_traffic();
		test_full_rate();
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_results.size() != 0)
			@(posedge clk);
		repeat (10) @(posedge clk);
		$display("Ran %0d requests (%0d on keys already held, %0d puts into full buckets),",
			request_count, hit_count, full_count);
		$display("directed corner cases, then random traffic with gaps and stalls.");
		if (fail_count == 0) begin
			$display("hash_table_key_value_store test passed");
		end else begin
			$display("hash_table_key_value_store test failed");
		end
		$finish;
	end

endmodule

`default_nettype wire
